// ===== sv/osda_pkg.sv =====
package osda_pkg;

  localparam int unsigned COUNT_W = 9;
  localparam int unsigned DATA_W  = 32;

  // operation codes
  localparam logic [2:0] OP_PUSH     = 3'd0;
  localparam logic [2:0] OP_POP      = 3'd1;
  localparam logic [2:0] OP_TOP      = 3'd2;
  localparam logic [2:0] OP_GET_DEEP = 3'd3;
  localparam logic [2:0] OP_SET_DEEP = 3'd4;
  localparam logic [2:0] OP_DROP     = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_DEPTH = 3'd3;
  localparam logic [2:0] ST_DROP  = 3'd4;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] value;
    logic [7:0]               depth_index;
    logic [COUNT_W-1:0]       drop_count;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

endpackage

// ===== sv/osda_ram.sv =====
module osda_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/operand_stack_with_deep_access.sv =====
// Bounded LIFO operand stack of 32-bit signed words.
// Request channel: a request word (operation, value, depth_index, drop_count)
// is taken at a rising edge where start is high and busy is low. Busy is
// high only in the first cycle after reset; after that a request may be
// issued every cycle.
// Result channel: exactly one result word per request, shown on result for
// one cycle with done high, in the cycle after the request was taken. The
// receiver cannot stall, so results are never held.
// Throughput is one request per clock. The entries sit in a single
// dual-port RAM with registered read: the read address is issued in the
// request cycle and the word comes back with the result, while writes
// (push, write deep) land at the request edge, so a read in the next cycle
// already sees them.
// Configuration: cfg_write with cfg_data sets the capacity; write only when
// no result is pending. A push fails once the count reaches
// min(capacity, STACK_DEPTH, 511).
// Reset (rst, synchronous) empties the stack and sets the capacity to 256;
// the RAM is not cleared, as only entries below the count are ever read.
module operand_stack_with_deep_access
  import osda_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               request,
  output logic               done,
  output rsp_t               result,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_data
);

  // the count never exceeds the largest capacity, so deeper storage is unused
  localparam int unsigned MAX_COUNT = (1 << COUNT_W) - 1;
  localparam int unsigned MEM_DEPTH = (STACK_DEPTH < MAX_COUNT) ? STACK_DEPTH : MAX_COUNT;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_LIMIT = COUNT_W'(MEM_DEPTH);
  localparam logic [COUNT_W-1:0] CAP_RESET   = COUNT_W'(256);

  logic [COUNT_W-1:0] capacity;
  logic [COUNT_W-1:0] live_count;
  logic [COUNT_W-1:0] live_count_next;
  logic               init;
  logic [2:0]         status;
  logic [2:0]         status_next;
  logic               read_ok;
  logic               read_ok_next;
  logic               full_flag;

  logic [COUNT_W-1:0] lim;
  logic [COUNT_W-1:0] depth_ext;
  logic [COUNT_W-1:0] deep_pos;
  logic               accept;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  assign accept    = start && !busy;
  assign busy      = init;
  assign lim       = (capacity < DEPTH_LIMIT) ? capacity : DEPTH_LIMIT;
  assign depth_ext = {1'b0, request.depth_index};
  assign deep_pos  = live_count - depth_ext - COUNT_W'(1);

  always_comb begin
    live_count_next = live_count;
    status_next     = ST_OK;
    read_ok_next    = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = live_count[AW-1:0];
    mem_raddr       = deep_pos[AW-1:0];
    unique case (request.operation)
      OP_PUSH: begin
        if (live_count >= lim) begin
          status_next = ST_FULL;
        end else begin
          mem_we          = accept;
          live_count_next = live_count + COUNT_W'(1);
        end
      end
      OP_POP, OP_TOP: begin
        mem_raddr = live_count[AW-1:0] - AW'(1);
        if (live_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          read_ok_next = 1'b1;
          if (request.operation == OP_POP) begin
            live_count_next = live_count - COUNT_W'(1);
          end
        end
      end
      OP_GET_DEEP, OP_SET_DEEP: begin
        mem_waddr = deep_pos[AW-1:0];
        if (live_count == '0) begin
          status_next = ST_EMPTY;
        end else if (depth_ext >= live_count) begin
          status_next = ST_DEPTH;
        end else if (request.operation == OP_GET_DEEP) begin
          read_ok_next = 1'b1;
        end else begin
          mem_we = accept;
        end
      end
      OP_DROP: begin
        if (request.drop_count > live_count) begin
          status_next = ST_DROP;
        end else begin
          live_count_next = live_count - request.drop_count;
        end
      end
      default: begin
        // unknown operation: no change, ok status
      end
    endcase
  end

  osda_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (request.value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init       <= 1'b1;
      capacity   <= CAP_RESET;
      live_count <= '0;
      done       <= 1'b0;
    end else begin
      init <= 1'b0;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      done <= accept;
      if (accept) begin
        live_count <= live_count_next;
      end
    end
  end

  // result payload, meaningful only while done is high
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      read_ok   <= read_ok_next;
      full_flag <= (live_count_next >= lim);
    end
  end

  always_comb begin
    result.status      = status;
    result.read_value  = read_ok ? mem_rdata : '0;
    result.entry_count = live_count;
    result.is_empty    = (live_count == '0);
    result.is_full     = full_flag;
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without an accepted request");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    live_count <= DEPTH_LIMIT)
    else $error("live count beyond storage");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && request.operation == OP_PUSH && status_next == ST_OK)
      |=> live_count == $past(live_count) + COUNT_W'(1))
    else $error("successful push did not grow the stack");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next != ST_OK) |=> live_count == $past(live_count))
    else $error("failed request changed the count");

  a_write_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (accept && status_next == ST_OK))
    else $error("entry write outside a successful request");

endmodule
